// File: hw/rtl/ddo_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the odometry block.
package ddo_pkg;

  // Default number of CORDIC iterations (sin/cos precision in bits).
  localparam int TRIG_BITS_DEF = 16;

  // Field and register widths fixed by the interface.
  localparam int TICK_W    = 16;
  localparam int POS_W     = 48;
  localparam int ANGLE_W   = 24;
  localparam int STEP_G_W  = 24;
  localparam int ANGLE_G_W = 20;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int ITER_W     = 5;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN = 2'd1;

  // Register values after reset.
  localparam logic [STEP_G_W-1:0]  STEP_GAIN_RST  = 24'd11810;
  localparam logic [ANGLE_G_W-1:0] ANGLE_GAIN_RST = 20'd5490;

  // CORDIC gain compensation 0.60725293500888 in Q32.
  localparam logic [63:0] CORDIC_GAIN_Q32 = 64'h0000_0000_9B74_EDA8;

  // Saturation limits of the position registers.
  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_TURN,
    ST_ROT,
    ST_MXL,
    ST_MXH,
    ST_MYL,
    ST_MYH,
    ST_FIN,
    ST_UPD,
    ST_DONE
  } state_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_D,
    OP_MUL_H,
    OP_ROT,
    OP_MXL,
    OP_MXH,
    OP_MYL,
    OP_MYH,
    OP_FIN,
    OP_UPD,
    OP_EMIT
  } dp_op_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    dp_op_t            op;
    logic [ITER_W-1:0] iter;
  } dp_cmd_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      default: val = 32'h0;
    endcase
    return val;
  endfunction

endpackage

// File: hw/rtl/ddo_ctrl.sv
// Controller state machine that sequences the odometry datapath.
module ddo_ctrl
  import ddo_pkg::*;
#(
  parameter int TRIG_BITS = TRIG_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(TRIG_BITS - 1);

  state_t            state;
  state_t            state_next;
  logic [ITER_W-1:0] iter;
  logic              emit;

  // The result slot is free when it is empty or being drained this cycle.
  assign emit = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ROT) begin
        iter <= iter + 1'b1;
      end else begin
        iter <= '0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_DIST;
      ST_DIST: state_next = ST_TURN;
      ST_TURN: state_next = ST_ROT;
      ST_ROT:  if (iter == LAST_ITER) state_next = ST_MXL;
      ST_MXL:  state_next = ST_MXH;
      ST_MXH:  state_next = ST_MYL;
      ST_MYL:  state_next = ST_MYH;
      ST_MYH:  state_next = ST_FIN;
      ST_FIN:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_DONE;
      ST_DONE: if (emit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    cmd.iter = iter;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_DIST: cmd.op = OP_MUL_D;
      ST_TURN: cmd.op = OP_MUL_H;
      ST_ROT:  cmd.op = OP_ROT;
      ST_MXL:  cmd.op = OP_MXL;
      ST_MXH:  cmd.op = OP_MXH;
      ST_MYL:  cmd.op = OP_MYL;
      ST_MYH:  cmd.op = OP_MYH;
      ST_FIN:  cmd.op = OP_FIN;
      ST_UPD:  cmd.op = OP_UPD;
      ST_DONE: if (emit) cmd.op = OP_EMIT;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: hw/rtl/ddo_datapath.sv
// Odometry datapath: pose registers, shared multiplier, CORDIC and gain registers.
module ddo_datapath
  import ddo_pkg::*;
#(
  parameter int TRIG_BITS = TRIG_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dp_cmd_t                      cmd,
  input  logic signed [TICK_W-1:0]     left_ticks,
  input  logic signed [TICK_W-1:0]     right_ticks,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic signed [POS_W-1:0]      pos_x,
  output logic signed [POS_W-1:0]      pos_y,
  output logic signed [ANGLE_W-1:0]    heading
);

  localparam int CW  = TRIG_BITS + 3;                          // CORDIC x/y width
  localparam int ZW  = 34;                                     // CORDIC angle width
  localparam int SW  = TICK_W + 1;                             // tick sum width
  localparam int MA  = STEP_G_W;                               // multiplier operand a
  localparam int MB  = (TRIG_BITS + 2 > SW) ? TRIG_BITS + 2 : SW;
  localparam int PW  = MA + MB;                                // product width
  localparam int DW  = 40;                                     // |distance| width
  localparam int HW  = DW / 2;                                 // half of |distance|
  localparam int AW  = DW + MB;                                // accumulator width
  localparam logic [63:0] XINIT_FULL =
    (CORDIC_GAIN_Q32 + (64'd1 << (31 - TRIG_BITS))) >> (32 - TRIG_BITS);

  // Configuration registers.
  logic [STEP_G_W-1:0]  step_gain;
  logic [ANGLE_G_W-1:0] angle_gain;

  // Pose and result registers.
  logic [POS_W-1:0]   x_pos;
  logic [POS_W-1:0]   y_pos;
  logic [ANGLE_W-1:0] head_angle;
  logic [POS_W-1:0]   out_x;
  logic [POS_W-1:0]   out_y;
  logic [ANGLE_W-1:0] out_h;

  // Per-item working registers.
  logic [SW-1:0]      sum_mag;
  logic               sum_neg;
  logic [SW-1:0]      diff_mag;
  logic               diff_neg;
  logic [DW-1:0]      dist_mag;
  logic [ANGLE_W-1:0] dh_mag;
  logic [PW-1:0]      prod;
  logic [AW-1:0]      acc;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [ZW-1:0] cz;
  logic               flip;

  // Combinational helpers.
  logic signed [SW-1:0] sum_s;
  logic signed [SW-1:0] diff_s;
  logic [1:0]           top;
  logic                 fold;
  logic [ANGLE_W-1:0]   h_fold;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] atan_z;
  logic [CW-1:0]        abs_x;
  logic [CW-1:0]        abs_y;
  logic [MA-1:0]        mul_a;
  logic [MB-1:0]        mul_b;
  logic                 neg_x;
  logic                 neg_y;
  logic [AW-1:0]        acc_sum;

  // Adds a signed, shifted magnitude to a position and saturates.
  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] p,
                                               input logic [AW-1:0]    mag,
                                               input logic             neg);
    logic [AW-1:0]    sh;
    logic [POS_W:0]   delta;
    logic [POS_W:0]   sum;
    logic [POS_W-1:0] res;
    sh    = mag >> TRIG_BITS;
    delta = {1'b0, sh[POS_W-1:0]};
    if (neg) delta = -delta;
    sum = {p[POS_W-1], p} + delta;
    if (sum[POS_W] != sum[POS_W-1]) begin
      res = sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      res = sum[POS_W-1:0];
    end
    return res;
  endfunction

  assign sum_s  = SW'(left_ticks) + SW'(right_ticks);
  assign diff_s = SW'(left_ticks) - SW'(right_ticks);

  // Fold the heading into a quarter turn around zero; the fold negates sin and cos.
  assign top    = head_angle[ANGLE_W-1:ANGLE_W-2];
  assign fold   = (top == 2'b01) || (top == 2'b10);
  assign h_fold = fold ? (head_angle ^ {1'b1, {(ANGLE_W-1){1'b0}}}) : head_angle;

  assign xs     = cx >>> cmd.iter;
  assign ys     = cy >>> cmd.iter;
  assign atan_z = ZW'(atan_entry(cmd.iter));

  assign abs_x = cx[CW-1] ? CW'(-cx) : CW'(cx);
  assign abs_y = cy[CW-1] ? CW'(-cy) : CW'(cy);

  assign neg_x   = sum_neg ^ cx[CW-1] ^ flip;
  assign neg_y   = sum_neg ^ cy[CW-1] ^ flip;
  assign acc_sum = acc + (AW'(prod) << HW);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_D: begin
        mul_a = step_gain;
        mul_b = MB'(sum_mag);
      end
      OP_MUL_H: begin
        mul_a = MA'(angle_gain);
        mul_b = MB'(diff_mag);
      end
      OP_MXL: begin
        mul_a = MA'(dist_mag[HW-1:0]);
        mul_b = MB'(abs_x);
      end
      OP_MXH: begin
        mul_a = MA'(dist_mag[DW-1:HW]);
        mul_b = MB'(abs_x);
      end
      OP_MYL: begin
        mul_a = MA'(dist_mag[HW-1:0]);
        mul_b = MB'(abs_y);
      end
      OP_MYH: begin
        mul_a = MA'(dist_mag[DW-1:HW]);
        mul_b = MB'(abs_y);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Control-side registers: gains and pose.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_gain  <= STEP_GAIN_RST;
      angle_gain <= ANGLE_GAIN_RST;
      x_pos      <= '0;
      y_pos      <= '0;
      head_angle <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STEP_GAIN:  step_gain  <= cfg_data[STEP_G_W-1:0];
          REG_ANGLE_GAIN: angle_gain <= cfg_data[ANGLE_G_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_MYH) begin
        x_pos <= sat_add(x_pos, acc, neg_x);
      end
      if (cmd.op == OP_UPD) begin
        y_pos      <= sat_add(y_pos, acc, neg_y);
        head_angle <= head_angle + (diff_neg ? ANGLE_W'(-dh_mag) : dh_mag);
      end
    end
  end

  // Working registers; no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) begin
      prod <= PW'(mul_a) * PW'(mul_b);
    end
    case (cmd.op)
      OP_LOAD: begin
        sum_neg  <= sum_s[SW-1];
        sum_mag  <= sum_s[SW-1] ? SW'(-sum_s) : SW'(sum_s);
        diff_neg <= diff_s[SW-1];
        diff_mag <= diff_s[SW-1] ? SW'(-diff_s) : SW'(diff_s);
        flip     <= fold;
        cx       <= XINIT_FULL[CW-1:0];
        cy       <= '0;
        cz       <= {{(ZW-ANGLE_W-8){h_fold[ANGLE_W-1]}}, h_fold, 8'd0};
      end
      OP_MUL_H: dist_mag <= prod[DW-1:0];
      OP_ROT: begin
        // The heading product is on the multiplier output only in the first rotation.
        if (cmd.iter == '0) begin
          dh_mag <= prod[ANGLE_W-1:0];
        end
        if (!cz[ZW-1]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_z;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_z;
        end
      end
      OP_MXH:  acc <= AW'(prod);
      OP_MYL:  acc <= acc_sum;
      OP_MYH:  acc <= AW'(prod);
      OP_FIN:  acc <= acc_sum;
      OP_EMIT: begin
        out_x <= x_pos;
        out_y <= y_pos;
        out_h <= head_angle;
      end
      default: ;
    endcase
  end

  assign pos_x   = out_x;
  assign pos_y   = out_y;
  assign heading = out_h;

endmodule

// File: hw/rtl/differential_drive_odometry.sv
// Top level of the differential-drive dead-reckoning odometry block.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    left_ticks, right_ticks
//   out      output     out_valid/out_ready  pos_x, pos_y, heading
//   cfg      input      cfg_we (no wait)     cfg_index, cfg_data
//
// A new item is taken only after the last one has gone into the result register.
// The pace is set by the CORDIC, which runs one rotation per cycle, and by
// the single shared multiplier, which forms the distance, the heading change
// and the four partial products of the x and y steps in turn.
// Reset (rst, synchronous, active high) zeroes the pose, loads the gain
// defaults and empties the result register.
// A stalled output holds the block only in its last step: the next item is
// taken and worked on while an earlier result waits for its transfer.
module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int TRIG_BITS = TRIG_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Tick input channel.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [TICK_W-1:0]  left_ticks,
  input  logic signed [TICK_W-1:0]  right_ticks,
  // Pose output channel.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [POS_W-1:0]   pos_x,
  output logic signed [POS_W-1:0]   pos_y,
  output logic signed [ANGLE_W-1:0] heading,
  // Configuration write port.
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  // The controller issues one datapath operation per cycle; the datapath keeps
  // all arithmetic state, the pose and the result register.
  dp_cmd_t cmd;

  ddo_ctrl #(
    .TRIG_BITS (TRIG_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The pose update uses the heading from before the item: x and y advance by
  // the distance times cos and sin of the old heading, and only then does the
  // heading take its change. Positions saturate; the heading wraps.
  ddo_datapath #(
    .TRIG_BITS (TRIG_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .left_ticks  (left_ticks),
    .right_ticks (right_ticks),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading)
  );

endmodule

// File: tb/differential_drive_odometry_test.sv
// Self-checking testbench for the differential-drive odometry block.
module differential_drive_odometry_test;
  import ddo_pkg::*;

  // The block runs with its default iteration count, and the pose model
  // below uses the same count.
  localparam int TRIG_ITERS = TRIG_BITS_DEF;

  // Register indexes that the block must ignore.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  // Length of the long receiver hold-off and the cycle budget of the run.
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  // CORDIC gain compensation in Q32 and atan(2^-i) in units of 2^-32 turn.
  localparam longint GAIN_Q32 = 64'h9B74EDA8;
  localparam logic [31:0] ATAN_TURN [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam longint POS_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint POS_LO = -POS_HI - 1;

  typedef struct {
    logic signed [TICK_W-1:0] left;
    logic signed [TICK_W-1:0] right;
  } tick_pair_t;

  typedef struct {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [ANGLE_W-1:0] h;
  } pose_t;

  // Every input of the block has a known value from time zero.
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [TICK_W-1:0]  left_ticks = '0;
  logic signed [TICK_W-1:0]  right_ticks = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic signed [ANGLE_W-1:0] heading;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  // Tick pairs waiting to be offered, and the poses the block owes us.
  tick_pair_t pending_ticks[$];
  pose_t      expected_poses[$];

  // Our own copy of the block's registers and pose.
  logic [STEP_G_W-1:0]  model_step_gain = STEP_GAIN_RST;
  logic [ANGLE_G_W-1:0] model_angle_gain = ANGLE_GAIN_RST;
  longint               model_x = 0;
  longint               model_y = 0;
  logic [ANGLE_W-1:0]   model_head = '0;

  int error_count = 0;
  int cycle_count = 0;

  // Sender and receiver pacing state.
  int send_wait = 0;
  int send_count = 0;
  bit send_calm = 1'b0;
  int recv_wait = 0;
  int poses_seen = 0;
  bit recv_calm = 1'b0;
  pose_t want_pose;

  differential_drive_odometry #(
    .TRIG_BITS(TRIG_ITERS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .left_ticks (left_ticks),
    .right_ticks(right_ticks),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .heading    (heading),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cosine and sine of a binary angle, scaled by 2^TRIG_ITERS. Angles in the
  // second and third quarter are rotated by a half turn first and the
  // results negated, so the rotation only ever covers [-1/4, 1/4) turn.
  function automatic void cordic_trig(input logic [ANGLE_W-1:0] angle,
                                      output longint cos_v, output longint sin_v);
    logic [ANGLE_W-1:0] folded;
    bit                 flip;
    longint             xr, yr, zr, xs, ys, step_ang;
    folded = angle;
    flip = 1'b0;
    if (folded[23:22] == 2'b01 || folded[23:22] == 2'b10) begin
      folded = folded ^ 24'h800000;
      flip = 1'b1;
    end
    zr = longint'($signed(folded));
    zr = zr * 256;
    xr = (GAIN_Q32 + (64'd1 << (31 - TRIG_ITERS))) >> (32 - TRIG_ITERS);
    yr = 0;
    for (int i = 0; i < TRIG_ITERS && i < 24; i++) begin
      xs = xr >>> i;
      ys = yr >>> i;
      step_ang = longint'(ATAN_TURN[i]);
      if (zr >= 0) begin
        xr = xr - ys;
        yr = yr + xs;
        zr = zr - step_ang;
      end else begin
        xr = xr + ys;
        yr = yr - xs;
        zr = zr + step_ang;
      end
    end
    cos_v = flip ? -xr : xr;
    sin_v = flip ? -yr : yr;
  endfunction

  // Distance times a trig value, divided by 2^TRIG_ITERS and truncated
  // toward zero. The magnitudes keep the product well inside 64 bits.
  function automatic longint scale_trig(input longint travel, input longint trig);
    bit              neg;
    longint unsigned mag_d, mag_t, prod;
    neg = (travel < 0) != (trig < 0);
    mag_d = (travel < 0) ? -travel : travel;
    mag_t = (trig < 0) ? -trig : trig;
    prod = (mag_d * mag_t) >> TRIG_ITERS;
    return neg ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic longint clamp48(input longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  // Advances our pose by one tick pair and records the pose the block must
  // report for it. The position step uses the heading from before the turn.
  function automatic void advance_pose(input logic signed [TICK_W-1:0] l,
                                       input logic signed [TICK_W-1:0] r);
    longint lt, rt, sg, ag, travel, cos_v, sin_v, turn;
    pose_t  p;
    lt = longint'(l);
    rt = longint'(r);
    sg = longint'(model_step_gain);
    ag = longint'(model_angle_gain);
    travel = sg * (lt + rt);
    cordic_trig(model_head, cos_v, sin_v);
    model_x = clamp48(model_x + scale_trig(travel, cos_v));
    model_y = clamp48(model_y + scale_trig(travel, sin_v));
    turn = ag * (lt - rt);
    model_head = model_head + turn[ANGLE_W-1:0];
    p.x = model_x[POS_W-1:0];
    p.y = model_y[POS_W-1:0];
    p.h = model_head;
    expected_poses.push_back(p);
  endfunction

  // Idle cycles for one transfer; a calm stretch has none at all.
  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // Driver. A tick pair is presented, held until its transfer, and then an
  // idle gap drawn for it is inserted before the next one goes out. The
  // pose model advances at the very edge of each input transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_pose(left_ticks, right_ticks);
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          left_ticks  <= pending_ticks[0].left;
          right_ticks <= pending_ticks[0].right;
          in_valid    <= 1'b1;
          void'(pending_ticks.pop_front());
          send_count++;
          if (send_count % 40 == 0) send_calm = ($urandom_range(0, 2) == 0);
          send_wait = draw_wait(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each output transfer is checked field by field against the
  // oldest outstanding pose. Twice during the long drive phase the receiver
  // holds off for HOLD_CYCLES so that the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_poses.size() == 0) begin
          $error("pose transfer with no pose outstanding: x %0d y %0d heading %0d",
                 pos_x, pos_y, heading);
          error_count++;
        end else begin
          want_pose = expected_poses.pop_front();
          if (pos_x !== want_pose.x) begin
            $error("pos_x mismatch: expected %0d, actual %0d", $signed(want_pose.x), pos_x);
            error_count++;
          end
          if (pos_y !== want_pose.y) begin
            $error("pos_y mismatch: expected %0d, actual %0d", $signed(want_pose.y), pos_y);
            error_count++;
          end
          if (heading !== want_pose.h) begin
            $error("heading mismatch: expected %0d, actual %0d",
                   $signed(want_pose.h), heading);
            error_count++;
          end
        end
        poses_seen++;
        if (poses_seen % 50 == 0) recv_calm = ($urandom_range(0, 2) == 0);
        if (poses_seen == 150 || poses_seen == 700) begin
          recv_wait = HOLD_CYCLES;
        end else begin
          recv_wait = draw_wait(recv_calm);
        end
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_ready <= (recv_wait == 0);
    end
  end

  // Watchdog: a run that hangs is a failing run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_tick(input logic signed [TICK_W-1:0] l,
                            input logic signed [TICK_W-1:0] r);
    tick_pair_t t;
    t.left = l;
    t.right = r;
    pending_ticks.push_back(t);
  endtask

  // One register write; the model takes the value as the block will, with
  // only the register's own width kept and unknown indexes dropped.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_STEP_GAIN:  model_step_gain = val[STEP_G_W-1:0];
      REG_ANGLE_GAIN: model_angle_gain = val[ANGLE_G_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every tick pair has gone in and every pose has come out,
  // so the block is idle and registers may be changed.
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_valid || expected_poses.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Straight runs at high speed with a random turn between them. With the
  // largest gains a run of a hundred or so items pushes a coordinate into
  // saturation.
  task automatic queue_drive(input int count);
    int                       n, seg;
    bit                       back;
    logic signed [TICK_W-1:0] speed;
    n = 0;
    while (n < count) begin
      seg = $urandom_range(20, 220);
      back = 1'($urandom_range(0, 1));
      for (int k = 0; k < seg; k++) begin
        speed = TICK_W'($urandom_range(20000, 32767));
        if (back) speed = ($urandom_range(0, 15) == 0) ? -16'sd32768 : -speed;
        queue_tick(speed, speed);
      end
      queue_tick(TICK_W'($urandom), TICK_W'($urandom));
      n += seg + 1;
    end
  endtask

  // General traffic: full-range ticks, small ticks, straight steps and
  // corner values of the tick range.
  task automatic queue_random(input int count);
    logic signed [TICK_W-1:0] l, r;
    logic signed [TICK_W-1:0] corner [0:4];
    corner = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 3))
        0: begin
          l = TICK_W'($urandom_range(0, 64)) - 16'sd32;
          r = TICK_W'($urandom_range(0, 64)) - 16'sd32;
        end
        1: begin
          l = TICK_W'($urandom);
          r = l;
        end
        2: begin
          l = corner[$urandom_range(0, 4)];
          r = corner[$urandom_range(0, 4)];
        end
        default: begin
          l = TICK_W'($urandom);
          r = TICK_W'($urandom);
        end
      endcase
      queue_tick(l, r);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Gains at their reset values. The tick extremes come in pairs whose
    // heading changes cancel, so the heading ends this phase back at zero.
    queue_tick(16'sd0, 16'sd0);
    queue_tick(16'sd32767, 16'sd32767);
    queue_tick(-16'sd32768, -16'sd32768);
    queue_tick(16'sd32767, -16'sd32768);
    queue_tick(-16'sd32768, 16'sd32767);
    queue_tick(16'sd1, 16'sd0);
    queue_tick(16'sd0, 16'sd1);
    queue_tick(-16'sd1, 16'sd0);
    queue_tick(16'sd0, -16'sd1);
    queue_tick(16'sd12345, -16'sd321);
    queue_tick(-16'sd321, 16'sd12345);
    queue_tick(-16'sd1, -16'sd1);
    wait_drained();

    // An angle gain of 2^19 (written with high bits that must be dropped)
    // makes a tick difference of 8 exactly a quarter turn. Starting from
    // zero this walks the heading over every quarter boundary, through the
    // half turn that reads as the most negative angle. Writes to the unused
    // indexes must leave both gains alone.
    write_reg(REG_STEP_GAIN, 24'h123456);
    write_reg(REG_ANGLE_GAIN, 24'hF80000);
    write_reg(REG_UNUSED_2, 24'hFFFFFF);
    write_reg(REG_UNUSED_3, 24'hABCDEF);
    queue_tick(16'sd8, 16'sd0);
    queue_tick(16'sd5, -16'sd3);
    queue_tick(16'sd4, -16'sd4);
    queue_tick(16'sd20, 16'sd12);
    queue_tick(16'sd16, 16'sd0);
    queue_tick(16'sd32767, 16'sd32767);
    queue_tick(-16'sd1, 16'sd7);
    queue_tick(16'sd0, -16'sd32768);
    queue_tick(-16'sd32768, 16'sd0);
    wait_drained();

    // Largest gains: long straight runs drive the position into both
    // saturation limits.
    write_reg(REG_STEP_GAIN, 24'hFFFFFF);
    write_reg(REG_ANGLE_GAIN, 24'hFFFFFF);
    queue_drive(800);
    wait_drained();

    // Zero gains: the pose must not move at all.
    write_reg(REG_STEP_GAIN, 24'h000000);
    write_reg(REG_ANGLE_GAIN, 24'h000000);
    queue_random(40);
    wait_drained();

    // Random gains, with a stray write to an unused index each time.
    repeat (3) begin
      write_reg(REG_STEP_GAIN, CFG_DATA_W'($urandom));
      write_reg(REG_ANGLE_GAIN, CFG_DATA_W'($urandom));
      write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3, CFG_DATA_W'($urandom));
      queue_random(170);
      wait_drained();
    end

    // Give a stray late result time to show up before the verdict.
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
